// ===== hw/rtl/c2qa_pkg.sv =====
// ----------------------------------------------------------------------------
// c2qa_pkg
// Types, widths and constants shared by the cartesian-to-angles pipeline.
// ----------------------------------------------------------------------------
package c2qa_pkg;

    localparam int THETA_STEPS_DFLT   = 128;
    localparam int THETA_LIMIT_DFLT   = 127;
    localparam int PHI_STEPS_DFLT     = 1024;
    localparam int PHI_LIMIT_DFLT     = 1023;
    localparam int CORDIC_STAGES_DFLT = 20;

    localparam int COORD_W    = 16;
    localparam int EL_W       = 7;
    localparam int AZ_W       = 10;
    localparam int TURN_BITS  = 24;
    localparam int ANG_W      = 26;
    localparam int QANG_W     = 25;
    localparam int CW         = 28;
    localparam int SQ_W       = 31;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 24;
    localparam int REM_W      = 26;
    localparam int SQRT_STEPS = 24;
    localparam int ROUND_HALF = 1 << (TURN_BITS - 1);

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd4194304;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 26'sd8388608;
    localparam logic [QANG_W-1:0]       FULL_TURN    = 25'd16777216;

    localparam logic [ANG_W-1:0] ATAN_TABLE [32] = '{
        26'd2097152, 26'd1238021, 26'd654136, 26'd332050,
        26'd166669,  26'd83416,   26'd41718,  26'd20860,
        26'd10430,   26'd5215,    26'd2608,   26'd1304,
        26'd652,     26'd326,     26'd163,    26'd81,
        26'd41,      26'd20,      26'd10,     26'd5,
        26'd3,       26'd1,       26'd1,      26'd0,
        26'd0,       26'd0,       26'd0,      26'd0,
        26'd0,       26'd0,       26'd0,      26'd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } point_t;

    typedef struct packed {
        logic [EL_W-1:0] elevation_step;
        logic [AZ_W-1:0] azimuth_step;
    } angle_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic                      y_pos;
        logic                      x_pos;
        logic                      az_nz;
        logic signed [CW-1:0]      az_a;
        logic signed [CW-1:0]      az_b;
        logic signed [ANG_W-1:0]   az_ang;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0]    el_a;
        logic signed [CW-1:0]    el_b;
        logic signed [ANG_W-1:0] el_ang;
        logic signed [CW-1:0]    az_a;
        logic signed [CW-1:0]    az_b;
        logic signed [ANG_W-1:0] az_ang;
        logic                    y_pos;
        logic                    x_pos;
        logic                    az_nz;
    } cordic_t;

endpackage

// ===== hw/rtl/c2qa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// c2qa_sqrt_cell
// One restoring square-root digit: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module c2qa_sqrt_cell
    import c2qa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  sqrt_t up_data,
    output logic  up_stall,
    output logic  dn_valid,
    output sqrt_t dn_data,
    input  logic  dn_stall
);

    logic              valid_reg;
    sqrt_t             data_reg;
    sqrt_t             data_next;
    logic [REM_W+1:0]  acc;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        acc       = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
        trial     = {2'b00, up_data.root, 2'b01};
        data_next = up_data;
        data_next.rad = {up_data.rad[RAD_W-3:0], 2'b00};
        if (acc >= trial)
        begin
            data_next.rem  = REM_W'(acc - trial);
            data_next.root = {up_data.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = REM_W'(acc);
            data_next.root = {up_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall)
        begin
            data_reg <= data_next;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.rem <= REM_W'({data_reg.root, 1'b0}))
        else $error("sqrt remainder exceeds twice the root");

endmodule

// ===== hw/rtl/c2qa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// c2qa_cordic_cell
// One vectoring micro-rotation for both the elevation and azimuth vectors.
// ----------------------------------------------------------------------------
module c2qa_cordic_cell
    import c2qa_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  cordic_t up_data,
    output logic    up_stall,
    output logic    dn_valid,
    output cordic_t dn_data,
    input  logic    dn_stall
);

    localparam logic signed [ANG_W-1:0] ATAN = ATAN_TABLE[STAGE];

    logic                    valid_reg;
    cordic_t                 data_reg;
    cordic_t                 data_next;
    logic signed [CW-1:0]    el_a;
    logic signed [CW-1:0]    el_b;
    logic signed [ANG_W-1:0] el_ang;
    logic signed [CW-1:0]    az_a;
    logic signed [CW-1:0]    az_b;
    logic signed [ANG_W-1:0] az_ang;

    always_comb
    begin
        el_a      = up_data.el_a;
        el_b      = up_data.el_b;
        el_ang    = up_data.el_ang;
        az_a      = up_data.az_a;
        az_b      = up_data.az_b;
        az_ang    = up_data.az_ang;
        data_next = up_data;
        if (!el_b[CW-1])
        begin
            data_next.el_a   = el_a + (el_b >>> STAGE);
            data_next.el_b   = el_b - (el_a >>> STAGE);
            data_next.el_ang = el_ang + ATAN;
        end
        else
        begin
            data_next.el_a   = el_a - (el_b >>> STAGE);
            data_next.el_b   = el_b + (el_a >>> STAGE);
            data_next.el_ang = el_ang - ATAN;
        end
        if (!az_b[CW-1])
        begin
            data_next.az_a   = az_a + (az_b >>> STAGE);
            data_next.az_b   = az_b - (az_a >>> STAGE);
            data_next.az_ang = az_ang + ATAN;
        end
        else
        begin
            data_next.az_a   = az_a - (az_b >>> STAGE);
            data_next.az_b   = az_b + (az_a >>> STAGE);
            data_next.az_ang = az_ang - ATAN;
        end
    end

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/cartesian_to_quantized_angles_core.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_quantized_angles_core
// Point (x, y, z) to quantized elevation and azimuth steps.
//
//   channel   direction  handshake                 payload
//   point     in         point_valid / point_stall point_t (coord_x, _y, _z)
//   angle     out        angle_valid / angle_stall angle_t (elevation, azimuth)
//
// The row holds two front stages (squares, sum), 24 square-root digit cells,
// one CORDIC cell per stage, then clamp, scale and round stages. One item
// enters per cycle through the fully pipelined row while no stage stalls.
// Reset clears all valid bits; payload registers are not reset.
// Each stage holds only while it is full and the stage after it holds, so
// empty slots fill up while the angle port stalls.
// ----------------------------------------------------------------------------
module cartesian_to_quantized_angles_core
    import c2qa_pkg::*;
#(
    parameter int THETA_STEPS   = THETA_STEPS_DFLT,
    parameter int THETA_LIMIT   = THETA_LIMIT_DFLT,
    parameter int PHI_STEPS     = PHI_STEPS_DFLT,
    parameter int PHI_LIMIT     = PHI_LIMIT_DFLT,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DFLT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  point_t point,
    output logic   angle_valid,
    input  logic   angle_stall,
    output angle_t angle
);

    localparam int EL_MULT = 4 * THETA_STEPS;
    localparam int EL_MW   = $clog2(EL_MULT + 1);
    localparam int AZ_MW   = $clog2(PHI_STEPS + 1);
    localparam int EL_PW   = QANG_W + EL_MW;
    localparam int AZ_PW   = QANG_W + AZ_MW;
    localparam int EL_SW   = EL_PW + 1;
    localparam int AZ_SW   = AZ_PW + 1;
    localparam int EL_QW   = EL_SW - TURN_BITS;
    localparam int AZ_QW   = AZ_SW - TURN_BITS;

    // front stage
    logic                      va_reg;
    logic [SQ_W-1:0]           xx_reg;
    logic [SQ_W-1:0]           zz_reg;
    side_t                     side_a_reg;
    side_t                     side_a_next;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] zs;
    logic signed [2*COORD_W-1:0] x_sq;
    logic signed [2*COORD_W-1:0] z_sq;
    logic signed [COORD_W:0]   x_ext;
    logic [COORD_W:0]          x_abs;
    logic signed [CW-1:0]      a0;
    logic signed [CW-1:0]      b0;
    logic                      stall_a;

    // sum stage
    logic  vb_reg;
    sqrt_t sb_reg;
    logic  stall_b;

    // cell rows
    logic    sq_valid [0:SQRT_STEPS];
    sqrt_t   sq_data  [0:SQRT_STEPS];
    logic    sq_stall [0:SQRT_STEPS];
    logic    cd_valid [0:CORDIC_STAGES];
    cordic_t cd_data  [0:CORDIC_STAGES];
    logic    cd_stall [0:CORDIC_STAGES];
    sqrt_t   sq_last;
    cordic_t cd_first;

    // clamp stage
    logic                    fa_valid_reg;
    logic [QANG_W-1:0]       fa_el_reg;
    logic [QANG_W-1:0]       fa_az_reg;
    logic                    fa_xpos_reg;
    logic [QANG_W-1:0]       fa_el_next;
    logic [QANG_W-1:0]       fa_az_next;
    logic [QANG_W-1:0]       az_clamp;
    cordic_t                 cd_last;
    logic signed [ANG_W-1:0] el_ang;
    logic signed [ANG_W-1:0] az_ang;
    logic                    stall_fa;

    // scale stage
    logic             fb_valid_reg;
    logic [EL_PW-1:0] el_prod_reg;
    logic [AZ_PW-1:0] az_prod_reg;
    logic             stall_fb;

    // round stage
    logic             out_valid_reg;
    angle_t           out_reg;
    angle_t           out_next;
    logic [EL_SW-1:0] el_sum;
    logic [AZ_SW-1:0] az_sum;
    logic [EL_QW-1:0] el_q;
    logic [AZ_QW-1:0] az_q;
    logic             stall_c;

    // ---------------- front: squares and azimuth setup ----------------
    always_comb
    begin
        xs    = point.coord_x;
        ys    = point.coord_y;
        zs    = point.coord_z;
        x_sq  = xs * xs;
        z_sq  = zs * zs;
        x_ext = {xs[COORD_W-1], xs};
        x_abs = x_ext[COORD_W] ? (COORD_W+1)'(-x_ext) : (COORD_W+1)'(x_ext);
        a0    = {{(CW-COORD_W-8){zs[COORD_W-1]}}, zs, 8'b0};
        b0    = {{(CW-COORD_W-9){1'b0}}, x_abs, 8'b0};
        side_a_next.y     = ys;
        side_a_next.y_pos = !ys[COORD_W-1] && (ys != '0);
        side_a_next.x_pos = !xs[COORD_W-1] && (xs != '0);
        side_a_next.az_nz = (xs != '0) || (zs != '0);
        if (zs[COORD_W-1])
        begin
            side_a_next.az_a   = b0;
            side_a_next.az_b   = -a0;
            side_a_next.az_ang = QUARTER_TURN;
        end
        else
        begin
            side_a_next.az_a   = a0;
            side_a_next.az_b   = b0;
            side_a_next.az_ang = '0;
        end
    end

    assign stall_a     = va_reg && stall_b;
    assign point_stall = stall_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (!stall_a)
        begin
            va_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_a)
        begin
            xx_reg     <= SQ_W'(x_sq);
            zz_reg     <= SQ_W'(z_sq);
            side_a_reg <= side_a_next;
        end
    end

    // ---------------- sum of squares ----------------
    assign stall_b = vb_reg && sq_stall[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (!stall_b)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_b)
        begin
            sb_reg.rad  <= RAD_W'({1'b0, xx_reg} + {1'b0, zz_reg});
            sb_reg.rem  <= '0;
            sb_reg.root <= '0;
            sb_reg.side <= side_a_reg;
        end
    end

    // ---------------- square-root row ----------------
    assign sq_valid[0] = vb_reg;
    assign sq_data[0]  = sb_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        c2qa_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_valid[k]),
            .up_data  (sq_data[k]),
            .up_stall (sq_stall[k]),
            .dn_valid (sq_valid[k+1]),
            .dn_data  (sq_data[k+1]),
            .dn_stall (sq_stall[k+1])
        );
    end

    assign sq_stall[SQRT_STEPS] = cd_stall[0];
    assign sq_last              = sq_data[SQRT_STEPS];
    assign cd_valid[0]          = sq_valid[SQRT_STEPS];

    always_comb
    begin
        cd_first.el_a   = CW'(sq_last.root);
        cd_first.el_b   = {{(CW-COORD_W-8){sq_last.side.y[COORD_W-1]}},
                           sq_last.side.y, 8'b0};
        cd_first.el_ang = '0;
        cd_first.az_a   = sq_last.side.az_a;
        cd_first.az_b   = sq_last.side.az_b;
        cd_first.az_ang = sq_last.side.az_ang;
        cd_first.y_pos  = sq_last.side.y_pos;
        cd_first.x_pos  = sq_last.side.x_pos;
        cd_first.az_nz  = sq_last.side.az_nz;
    end

    assign cd_data[0] = cd_first;

    // ---------------- CORDIC row ----------------
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        c2qa_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cd_valid[k]),
            .up_data  (cd_data[k]),
            .up_stall (cd_stall[k]),
            .dn_valid (cd_valid[k+1]),
            .dn_data  (cd_data[k+1]),
            .dn_stall (cd_stall[k+1])
        );
    end

    assign cd_stall[CORDIC_STAGES] = stall_fa;
    assign cd_last                 = cd_data[CORDIC_STAGES];

    // ---------------- clamp and mirror ----------------
    always_comb
    begin
        el_ang = cd_last.el_ang;
        az_ang = cd_last.az_ang;
        if (!cd_last.y_pos || el_ang < 0)
        begin
            fa_el_next = '0;
        end
        else if (el_ang > QUARTER_TURN)
        begin
            fa_el_next = QANG_W'(QUARTER_TURN);
        end
        else
        begin
            fa_el_next = QANG_W'(el_ang);
        end

        if (az_ang < 0)
        begin
            az_clamp = '0;
        end
        else if (az_ang > HALF_TURN)
        begin
            az_clamp = QANG_W'(HALF_TURN);
        end
        else
        begin
            az_clamp = QANG_W'(az_ang);
        end

        if (!cd_last.az_nz)
        begin
            fa_az_next = '0;
        end
        else if (cd_last.x_pos)
        begin
            fa_az_next = FULL_TURN - az_clamp;
        end
        else
        begin
            fa_az_next = az_clamp;
        end
    end

    assign stall_fa = fa_valid_reg && stall_fb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_valid_reg <= 1'b0;
        end
        else if (!stall_fa)
        begin
            fa_valid_reg <= cd_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_fa)
        begin
            fa_el_reg   <= fa_el_next;
            fa_az_reg   <= fa_az_next;
            fa_xpos_reg <= cd_last.x_pos;
        end
    end

    // ---------------- scale to steps ----------------
    assign stall_fb = fb_valid_reg && stall_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_valid_reg <= 1'b0;
        end
        else if (!stall_fb)
        begin
            fb_valid_reg <= fa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_fb)
        begin
            el_prod_reg <= EL_PW'(fa_el_reg) * EL_PW'(EL_MULT);
            az_prod_reg <= AZ_PW'(fa_az_reg) * AZ_PW'(PHI_STEPS);
        end
    end

    // ---------------- round, limit and output ----------------
    always_comb
    begin
        el_sum = EL_SW'(el_prod_reg) + EL_SW'(ROUND_HALF);
        az_sum = AZ_SW'(az_prod_reg) + AZ_SW'(ROUND_HALF);
        el_q   = EL_QW'(el_sum >> TURN_BITS);
        az_q   = AZ_QW'(az_sum >> TURN_BITS);
        out_next.elevation_step = (32'(el_q) > 32'(THETA_LIMIT)) ?
                                  EL_W'(THETA_LIMIT) : EL_W'(el_q);
        out_next.azimuth_step   = (32'(az_q) > 32'(PHI_LIMIT)) ?
                                  AZ_W'(PHI_LIMIT) : AZ_W'(az_q);
    end

    assign stall_c     = out_valid_reg && angle_stall;
    assign angle_valid = out_valid_reg;
    assign angle       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!stall_c)
        begin
            out_valid_reg <= fb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_c)
        begin
            out_reg <= out_next;
        end
    end

    a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
        fa_valid_reg |-> fa_el_reg <= QANG_W'(QUARTER_TURN))
        else $error("elevation angle above a quarter turn");

    a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
        fa_valid_reg |-> fa_az_reg <= FULL_TURN)
        else $error("azimuth angle above a full turn");

    a_az_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        fa_valid_reg && (fa_az_reg == '0) |-> !fa_xpos_reg)
        else $error("mirrored azimuth came out zero");

    a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fb_valid_reg && stall_fb |=> fb_valid_reg && $stable(el_prod_reg)
                                     && $stable(az_prod_reg))
        else $error("scale stage lost an item while held");

endmodule
